// ===== hdl/nps_pkg.sv =====
`default_nettype none

package nps_pkg;

	// Table sizing
	localparam int MAX_NODES = 1024;
	localparam int ADDR_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int IDX_W     = 10;

	// Datapath widths
	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * COORD_W + 1;
	localparam int DIST_W  = SQ_W + 1;

	// Operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]                op;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] heading;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] node_index;
		logic [1:0]       status;
	} rsp_t;

	// One stored table entry
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] h;
	} pose_t;

	localparam int POSE_W = $bits(pose_t);

	// Tag that follows a table read through the distance pipe
	typedef struct packed {
		logic              valid;
		logic              last;
		logic [ADDR_W-1:0] idx;
	} scan_tag_t;

	// Distance pipe output
	typedef struct packed {
		logic              valid;
		logic              last;
		logic [ADDR_W-1:0] idx;
		logic [DIST_W-1:0] dist_sq;
	} dist_res_t;

endpackage

`default_nettype wire

// ===== hdl/nps_ram.sv =====
`default_nettype none

module nps_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/nps_dist.sv =====
`default_nettype none

module nps_dist
	import nps_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  scan_tag_t      tag,
	input  pose_t          rdata,
	input  pose_t          qry,
	output dist_res_t      res
);

	scan_tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2, dh_s2;
	logic [SQ_W-1:0]          sx_s3, sy_s3, sh_s3;
	logic signed [DIFF_W-1:0] dx, dy, dh;
	logic signed [2*DIFF_W-1:0] px, py, ph;
	logic [DIST_W-1:0]        sum_s4;

	// Differences against the query
	assign dx = DIFF_W'(rdata.x) - DIFF_W'(qry.x);
	assign dy = DIFF_W'(rdata.y) - DIFF_W'(qry.y);
	assign dh = DIFF_W'(rdata.h) - DIFF_W'(qry.h);

	// Squares, never negative
	assign px = dx_s2 * dx_s2;
	assign py = dy_s2 * dy_s2;
	assign ph = dh_s2 * dh_s2;

	// Tag pipe: s1 lines up with RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// Data pipe: diff, square, sum
	always_ff @(posedge clk) begin
		dx_s2  <= dx;
		dy_s2  <= dy;
		dh_s2  <= dh;
		sx_s3  <= px[SQ_W-1:0];
		sy_s3  <= py[SQ_W-1:0];
		sh_s3  <= ph[SQ_W-1:0];
		sum_s4 <= DIST_W'(sx_s3) + DIST_W'(sy_s3) + DIST_W'(sh_s3);
	end

	assign res = '{valid: tag_s4.valid, last: tag_s4.last, idx: tag_s4.idx, dist_sq: sum_s4};

endmodule

`default_nettype wire

// ===== hdl/nearest_pose_search.sv =====
// Channel   Handshake          Payload  Notes
// request   start / busy       req      taken when start & !busy
// result    done (strobe)      rsp      valid for one cycle, no stall
//
// Insert, clear and empty query: result in the cycle after the request, busy
// stays low, so these run at one per cycle.
// Query on N stored poses: busy until the result strobe; the pose RAM is read once
// per cycle, one entry per read, then the 4-stage distance pipe drains.
// Reset empties the table at once (count to zero); no RAM clearing pass.
// The receiver cannot stall; each request gives exactly one result.
`default_nettype none

module nearest_pose_search
	import nps_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  req_t      req,
	output logic      done,
	output rsp_t      rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] scan_q;
	logic              busy_q;
	logic              done_q;
	rsp_t              rsp_q;
	pose_t             qry_q;
	logic [DIST_W-1:0] best_q;
	logic [ADDR_W-1:0] best_idx_q;

	logic              accept;
	logic              full;
	logic              wr_en;
	pose_t             wr_pose;
	pose_t             rd_pose;
	scan_tag_t         tag;
	dist_res_t         dres;
	logic              take;

	assign accept  = start && !busy_q;
	assign full    = (count_q >= CNT_W'(MAX_NODES));
	assign wr_en   = accept && (req.op == OP_INSERT) && !full;
	assign wr_pose = '{x: req.pos_x, y: req.pos_y, h: req.heading};

	// Read issue during the scan
	assign tag.valid = (state_q == S_SCAN);
	assign tag.idx   = scan_q;
	assign tag.last  = ((CNT_W'(scan_q) + CNT_W'(1)) == count_q);

	nps_ram #(
		.WIDTH(POSE_W),
		.DEPTH(MAX_NODES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(wr_pose),
		.re   (tag.valid),
		.raddr(scan_q),
		.rdata(rd_pose)
	);

	nps_dist u_dist (
		.clk   (clk),
		.arst_n(arst_n),
		.tag   (tag),
		.rdata (rd_pose),
		.qry   (qry_q),
		.res   (dres)
	);

	// First entry always wins; later ones only when strictly nearer
	assign take = dres.valid && ((dres.idx == '0) || (dres.dist_sq < best_q));

	// Query and running minimum
	always_ff @(posedge clk) begin
		if (accept) begin
			qry_q <= wr_pose;
		end
		if (take) begin
			best_q     <= dres.dist_sq;
			best_idx_q <= dres.idx;
		end
	end

	// Control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.op)
							OP_INSERT: begin
								done_q <= 1'b1;
								if (full) begin
									rsp_q <= '{node_index: '0, status: ST_FULL};
								end else begin
									rsp_q   <= '{node_index: IDX_W'(count_q), status: ST_OK};
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_QUERY: begin
								if (count_q == '0) begin
									done_q <= 1'b1;
									rsp_q  <= '{node_index: '0, status: ST_EMPTY};
								end else begin
									done_q  <= 1'b0;
									scan_q  <= '0;
									busy_q  <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							OP_CLEAR: begin
								done_q  <= 1'b1;
								rsp_q   <= '{node_index: '0, status: ST_OK};
								count_q <= '0;
							end
							default: begin
								done_q <= 1'b1;
								rsp_q  <= '{node_index: '0, status: ST_OK};
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				S_SCAN: begin
					done_q <= 1'b0;
					scan_q <= scan_q + ADDR_W'(1);
					if (tag.last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (dres.valid && dres.last) begin
						done_q  <= 1'b1;
						rsp_q   <= '{node_index: take ? IDX_W'(dres.idx) : IDX_W'(best_idx_q),
							status: ST_OK};
						busy_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						done_q <= 1'b0;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

// ===== hdl/nps_checker.sv =====
`default_nettype none

module nps_checker
	import nps_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input req_t      req,
	input wire logic done,
	input rsp_t      rsp
);

	// No result while a query scan is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Non-query requests answer in the next cycle
	a_fast_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.op != OP_QUERY)) |=> done)
		else $error("missing result for insert/clear");

	// End of a scan always yields a result
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan ended without result");

	// Empty and full answers carry index zero
	a_err_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ((rsp.status == ST_EMPTY) || (rsp.status == ST_FULL)))
		|-> (rsp.node_index == '0))
		else $error("nonzero index on error status");

	// Status is a defined code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((rsp.status == ST_OK) || (rsp.status == ST_EMPTY)
			|| (rsp.status == ST_FULL)))
		else $error("undefined status code");

endmodule

bind nearest_pose_search nps_checker u_nps_checker (.*);

`default_nettype wire
